// ----- rtl/core/dnsap_pkg.sv -----
package dnsap_pkg;

  // One byte of the message as it sits in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Parse outcome for the message that ends with the current byte
  typedef struct packed {
    logic        found;
    logic [31:0] address;
  } result_t;

  localparam logic [15:0] ExpectedIdReset = 16'hABCD;
  localparam logic [7:0]  QrMask          = 8'h80;
  localparam logic [7:0]  PtrMask         = 8'hC0;

  // Header byte positions
  localparam logic [3:0] HdrIdHi    = 4'd0;
  localparam logic [3:0] HdrIdLo    = 4'd1;
  localparam logic [3:0] HdrFlagsHi = 4'd2;
  localparam logic [3:0] HdrQdHi    = 4'd4;
  localparam logic [3:0] HdrQdLo    = 4'd5;
  localparam logic [3:0] HdrAnHi    = 4'd6;
  localparam logic [3:0] HdrAnLo    = 4'd7;
  localparam logic [3:0] HdrLast    = 4'd11;

  // Answer fixed-field byte positions
  localparam logic [3:0] AnsTypeHi = 4'd0;
  localparam logic [3:0] AnsTypeLo = 4'd1;
  localparam logic [3:0] AnsLenHi  = 4'd8;
  localparam logic [3:0] AnsLenLo  = 4'd9;

  localparam logic [7:0]  QuestionTailBytes = 8'd4;
  localparam logic [3:0]  AddrBytes         = 4'd4;
  localparam logic [15:0] TypeA             = 16'd1;
  localparam logic [15:0] Ipv4Len           = 16'd4;

endpackage

// ----- rtl/core/dnsap_in_stage.sv -----
module dnsap_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              out_free_i,
  output dnsap_pkg::in_word_t word_o,
  output logic              consume_o
);
  import dnsap_pkg::*;

  logic     vld_q, vld_d;
  in_word_t word_q;
  logic     accept;

  // A non-last word never produces a result, so it always drains
  assign consume_o  = vld_q && (!word_q.last_byte || out_free_i);
  assign in_stall_o = vld_q && !consume_o;
  assign accept     = in_valid_i && !in_stall_o;
  assign word_o     = word_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (consume_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.data_byte <= data_byte_i;
      word_q.last_byte <= last_byte_i;
    end
  end

endmodule

// ----- rtl/core/dnsap_core.sv -----
module dnsap_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [15:0]         cfg_wr_data_i,
  input  dnsap_pkg::in_word_t word_i,
  input  logic                consume_i,
  output dnsap_pkg::result_t  result_o
);
  import dnsap_pkg::*;

  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhName   = 4'd1;
  localparam logic [3:0] PhLabel  = 4'd2;
  localparam logic [3:0] PhPtr    = 4'd3;
  localparam logic [3:0] PhQfixed = 4'd4;
  localparam logic [3:0] PhAfixed = 4'd5;
  localparam logic [3:0] PhAddr   = 4'd6;
  localparam logic [3:0] PhFound  = 4'd7;
  localparam logic [3:0] PhIgnore = 4'd8;

  logic [15:0] expected_id_q;
  logic [3:0]  phase_q, phase_d;
  logic [3:0]  header_index_q, header_index_d;
  logic [7:0]  skip_count_q, skip_count_d;
  logic [15:0] questions_left_q, questions_left_d;
  logic        header_ok_q, header_ok_d;
  logic [15:0] record_type_q, record_type_d;
  logic [15:0] record_length_q, record_length_d;
  logic [31:0] addr_acc_q, addr_acc_d;
  logic [3:0]  field_index_q, field_index_d;
  logic [7:0]  b;
  logic        found;

  assign b = word_i.data_byte;

  always_comb begin
    phase_d          = phase_q;
    header_index_d   = header_index_q;
    skip_count_d     = skip_count_q;
    questions_left_d = questions_left_q;
    header_ok_d      = header_ok_q;
    record_type_d    = record_type_q;
    record_length_d  = record_length_q;
    addr_acc_d       = addr_acc_q;
    field_index_d    = field_index_q;

    case (phase_q)
      PhHeader: begin
        case (header_index_q)
          HdrIdHi: begin
            if (b != expected_id_q[15:8]) header_ok_d = 1'b0;
          end
          HdrIdLo: begin
            if (b != expected_id_q[7:0]) header_ok_d = 1'b0;
          end
          HdrFlagsHi: begin
            if ((b & QrMask) == 8'h00) header_ok_d = 1'b0;
          end
          HdrQdHi: questions_left_d = {b, 8'h00};
          HdrQdLo: questions_left_d = {questions_left_q[15:8], b};
          HdrAnHi: record_type_d = {8'h00, b};
          HdrAnLo: begin
            // answer count zero: high byte parked in record_type
            if (record_type_q == 16'h0000 && b == 8'h00) header_ok_d = 1'b0;
            record_type_d = 16'h0000;
          end
          default: ;
        endcase
        if (header_index_q >= HdrLast) begin
          header_index_d = 4'd0;
          phase_d        = header_ok_d ? PhName : PhIgnore;
        end else begin
          header_index_d = header_index_q + 4'd1;
        end
      end
      PhName, PhPtr: begin
        if (phase_q == PhName && b != 8'h00) begin
          if ((b & PtrMask) == PtrMask) begin
            phase_d = PhPtr;
          end else begin
            skip_count_d = b;
            phase_d      = PhLabel;
          end
        end else if (questions_left_q != 16'h0000) begin
          skip_count_d = QuestionTailBytes;
          phase_d      = PhQfixed;
        end else begin
          field_index_d = 4'd0;
          phase_d       = PhAfixed;
        end
      end
      PhLabel: begin
        skip_count_d = skip_count_q - 8'd1;
        if (skip_count_d == 8'd0) phase_d = PhName;
      end
      PhQfixed: begin
        skip_count_d = skip_count_q - 8'd1;
        if (skip_count_d == 8'd0) begin
          questions_left_d = questions_left_q - 16'd1;
          phase_d          = PhName;
        end
      end
      PhAfixed: begin
        case (field_index_q)
          AnsTypeHi: record_type_d   = {b, 8'h00};
          AnsTypeLo: record_type_d   = {record_type_q[15:8], b};
          AnsLenHi:  record_length_d = {b, 8'h00};
          AnsLenLo:  record_length_d = {record_length_q[15:8], b};
          default: ;
        endcase
        if (field_index_q >= AnsLenLo) begin
          field_index_d = 4'd0;
          addr_acc_d    = 32'h0;
          if (record_type_d == TypeA && record_length_d == Ipv4Len) begin
            phase_d = PhAddr;
          end else begin
            phase_d = PhIgnore;
          end
        end else begin
          field_index_d = field_index_q + 4'd1;
        end
      end
      PhAddr: begin
        addr_acc_d    = {addr_acc_q[23:0], b};
        field_index_d = field_index_q + 4'd1;
        if (field_index_d >= AddrBytes) phase_d = PhFound;
      end
      default: ;
    endcase

    found = (phase_d == PhFound);
    result_o.found   = found;
    result_o.address = found ? addr_acc_d : 32'h0;

    // Rearm for the next message
    if (word_i.last_byte) begin
      phase_d          = PhHeader;
      header_index_d   = 4'd0;
      skip_count_d     = 8'd0;
      questions_left_d = 16'h0;
      header_ok_d      = 1'b1;
      record_type_d    = 16'h0;
      record_length_d  = 16'h0;
      addr_acc_d       = 32'h0;
      field_index_d    = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= ExpectedIdReset;
    end else if (cfg_wr_en_i) begin
      expected_id_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PhHeader;
      header_index_q   <= 4'd0;
      skip_count_q     <= 8'd0;
      questions_left_q <= 16'h0;
      header_ok_q      <= 1'b1;
      record_type_q    <= 16'h0;
      record_length_q  <= 16'h0;
      addr_acc_q       <= 32'h0;
      field_index_q    <= 4'd0;
    end else if (consume_i) begin
      phase_q          <= phase_d;
      header_index_q   <= header_index_d;
      skip_count_q     <= skip_count_d;
      questions_left_q <= questions_left_d;
      header_ok_q      <= header_ok_d;
      record_type_q    <= record_type_d;
      record_length_q  <= record_length_d;
      addr_acc_q       <= addr_acc_d;
      field_index_q    <= field_index_d;
    end
  end

endmodule

// ----- rtl/core/dnsap_out_stage.sv -----
module dnsap_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dnsap_pkg::result_t result_i,
  output logic               out_free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [31:0]        address_o
);
  import dnsap_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign out_free_o  = !vld_q || !out_stall_i;
  assign out_valid_o = vld_q;
  assign found_o     = res_q.found;
  assign address_o   = res_q.address;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

// ----- rtl/core/dns_a_record_response_parser.sv -----
// A last word waits in the input register; its result then goes to the result register once that is free.
// Throughput: one message word per cycle; a word enters every cycle the input
// register drains, which it does unless a last word meets a held result.
// Reset (rst_ni low, asynchronous): parse state returns to the header phase,
// both stage valids clear and expected_id returns to 0xABCD.
module dns_a_record_response_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_data_byte_i,
  input  logic        in_last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_found_o,
  output logic [31:0] out_address_o
);
  import dnsap_pkg::*;

  // Word path: input register -> parse update -> result register.
  in_word_t word;
  result_t  result;
  logic     consume;
  logic     out_free;

  // Hold the incoming word; drain it into the parser when it can move.
  dnsap_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (in_data_byte_i),
    .last_byte_i (in_last_byte_i),
    .out_free_i  (out_free),
    .word_o      (word),
    .consume_o   (consume)
  );

  // Advance the message parse by one byte; the result is formed from the
  // updated state so the last byte itself counts toward the address.
  dnsap_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .word_i        (word),
    .consume_i     (consume),
    .result_o      (result)
  );

  // Capture one result per message, on the last byte only.
  dnsap_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && word.last_byte),
    .result_i    (result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (out_found_o),
    .address_o   (out_address_o)
  );

endmodule

// ----- rtl/core/dnsap_checker.sv -----
module dnsap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_found_o,
  input logic [31:0] out_address_o
);

  // A held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_found_o)
      && $stable(out_address_o))
    else $error("held result changed");

  // No address escapes without a found record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |-> out_address_o == 32'h0)
    else $error("address nonzero with found clear");

  // Input backs up only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // Coming out of reset there is no result yet
  assert property (@(posedge clk_i)
    $past(!rst_ni) && rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("result present right after reset");

endmodule

bind dns_a_record_response_parser dnsap_checker u_dnsap_checker (.*);
